### rtl/wrss_pkg.sv
// Shared types and codes for the work range stealing scheduler.
package wrss_pkg;

  typedef enum logic [2:0] {
    REQ_INIT     = 3'd0,
    REQ_NEXT     = 3'd1,
    REQ_STEAL    = 3'd2,
    REQ_RST_ENDS = 3'd3,
    REQ_RST_POS  = 3'd4,
    REQ_READ     = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_NEXT,
    CELL_RST_ENDS,
    CELL_RST_POS,
    CELL_INIT,
    CELL_STEAL
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WAVE,
    ST_FINISH
  } state_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t    op;
    logic [3:0]  wid;
    logic [4:0]  n;
    logic [4:0]  extra;
    logic        take;
  } cell_ctrl_t;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 40;

endpackage

### rtl/wrss_cell.sv
// One worker cell: position, base end and working end, chained to its left neighbor.
module wrss_cell #(
  parameter int IDX         = 0,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wrss_pkg::cell_ctrl_t    ctrl,
  input  logic [INDEX_WIDTH-1:0]  share,
  input  logic [INDEX_WIDTH-1:0]  take,
  input  logic [INDEX_WIDTH-1:0]  prev_base,
  input  logic                    tok_in,
  output logic                    tok,
  output logic                    hit,
  output logic [INDEX_WIDTH-1:0]  base,
  output logic [INDEX_WIDTH-1:0]  wend,
  output logic [INDEX_WIDTH-1:0]  pos
);

  logic                   sel;
  logic                   active;
  logic [INDEX_WIDTH:0]   pos_inc;
  logic [INDEX_WIDTH-1:0] new_base;

  assign sel      = (int'(ctrl.wid) == IDX);
  assign active   = (IDX < int'(ctrl.n));
  assign pos_inc  = {1'b0, pos} + 1'b1;
  // at least two items left: pos + 1 < end, no wrap
  assign hit      = tok && (ctrl.op == wrss_pkg::CELL_STEAL) && (IDX > int'(ctrl.wid))
                    && active && (pos_inc < {1'b0, wend});
  assign new_base = prev_base + share + INDEX_WIDTH'(IDX < int'(ctrl.extra));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      base <= '0;
      wend <= '0;
      pos  <= '0;
    end else begin
      tok <= tok_in;
      case (ctrl.op)
        wrss_pkg::CELL_NEXT: begin
          if (sel) pos <= pos_inc[INDEX_WIDTH-1:0];
        end
        wrss_pkg::CELL_RST_ENDS: begin
          wend <= base;
        end
        wrss_pkg::CELL_RST_POS: begin
          if (active) pos <= prev_base;
        end
        wrss_pkg::CELL_INIT: begin
          if (tok) begin
            if (active) begin
              base <= new_base;
              wend <= new_base;
              pos  <= prev_base;
            end else begin
              base <= '0;
              wend <= '0;
              pos  <= '0;
            end
          end
        end
        wrss_pkg::CELL_STEAL: begin
          if (ctrl.take && hit) wend <= wend - 1'b1;
          if (ctrl.take && sel) pos <= take;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/wrss_div.sv
// Restoring divider, one quotient bit per cycle, for the share and remainder at init.
module wrss_div #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [INDEX_WIDTH-1:0] dividend,
  input  logic [4:0]             divisor,
  output logic [INDEX_WIDTH-1:0] quotient,
  output logic [4:0]             remainder,
  output logic                   last
);

  localparam int CW = $clog2(INDEX_WIDTH);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [5:0]    trial;
  logic          ge;

  assign trial = {remainder, quotient[INDEX_WIDTH-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign last  = busy && (cnt == CW'(INDEX_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[INDEX_WIDTH-2:0], ge};
      remainder <= ge ? 5'(trial - {1'b0, divisor}) : trial[4:0];
    end
  end

endmodule

### rtl/work_range_stealing_scheduler_core.sv
// Request to result: next, resets, read and a steal with a bad id go from exec to finish;
// a steal goes through exec, wave and finish; init through exec, the divider steps, the wave
// (one cell per cycle) and finish. The steal scan and the init build walk a token down
// the cell chain. One request at a time; the next is taken the cycle after the result is
// loaded, even while that result waits on m_tready. Synchronous active-high reset clears all
// limits and positions.
module work_range_stealing_scheduler_core #(
  parameter int MAX_WORKERS = 16,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wrss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wrss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wrss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wrss_pkg::S_DATA_W-1:0]       s_tdata,  // req_type[2:0], worker_id[6:3]
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wrss_pkg::M_DATA_W-1:0]       m_tdata   // granted[0], position[32:1], bad_worker[33]
);

  wrss_pkg::state_t     state, state_next;
  wrss_pkg::cell_ctrl_t ctrl;

  logic [31:0] item_count;
  logic [4:0]  worker_count;
  logic [4:0]  n;

  logic [2:0]  req_q;
  logic [3:0]  wid_q;
  logic        bad_q;
  logic        granted_q;

  logic                   inject;
  logic                   div_start;
  logic                   div_last;
  logic [INDEX_WIDTH-1:0] share;
  logic [4:0]             extra;

  logic [MAX_WORKERS-1:0] tok_vec;
  logic [MAX_WORKERS-1:0] hit_vec;
  logic [INDEX_WIDTH-1:0] base_arr [MAX_WORKERS];
  logic [INDEX_WIDTH-1:0] wend_arr [MAX_WORKERS];
  logic [INDEX_WIDTH-1:0] pos_arr  [MAX_WORKERS];

  logic [INDEX_WIDTH-1:0] sel_pos;
  logic [INDEX_WIDTH-1:0] sel_wend;
  logic [INDEX_WIDTH-1:0] hit_wend;
  logic [INDEX_WIDTH-1:0] take_val;
  logic [INDEX_WIDTH-1:0] next_pos;
  logic                   any_hit;
  logic                   accept;
  logic                   load_out;
  logic [31:0]            pos_out;

  // configuration
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'b0, worker_count} : item_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count   <= '0;
      worker_count <= 5'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) worker_count <= pwdata[4:0];
      else          item_count   <= pwdata;
    end
  end

  // effective worker count
  always_comb begin
    if (worker_count == 5'd0)                     n = 5'd1;
    else if (int'(worker_count) > MAX_WORKERS)    n = 5'(MAX_WORKERS);
    else                                          n = worker_count;
  end

  // cell chain
  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    logic [INDEX_WIDTH-1:0] prev_base;
    logic                   tok_in;
    if (k == 0) begin : g_head
      assign prev_base = '0;
      assign tok_in    = inject;
    end else begin : g_link
      assign prev_base = base_arr[k-1];
      assign tok_in    = tok_vec[k-1];
    end
    wrss_cell #(
      .IDX        (k),
      .INDEX_WIDTH(INDEX_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .share    (share),
      .take     (take_val),
      .prev_base(prev_base),
      .tok_in   (tok_in),
      .tok      (tok_vec[k]),
      .hit      (hit_vec[k]),
      .base     (base_arr[k]),
      .wend     (wend_arr[k]),
      .pos      (pos_arr[k])
    );
  end

  wrss_div #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (INDEX_WIDTH'(item_count)),
    .divisor  (n),
    .quotient (share),
    .remainder(extra),
    .last     (div_last)
  );

  // selection over the cells
  always_comb begin
    sel_pos  = '0;
    sel_wend = '0;
    hit_wend = '0;
    for (int k = 0; k < MAX_WORKERS; k++) begin
      if (int'(wid_q) == k) begin
        sel_pos  = pos_arr[k];
        sel_wend = wend_arr[k];
      end
      if (hit_vec[k]) hit_wend = wend_arr[k];
    end
  end

  assign any_hit  = |hit_vec;
  assign take_val = hit_wend - 1'b1;
  assign next_pos = sel_pos + 1'b1;
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == wrss_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  assign pos_out  = bad_q ? 32'd0 : 32'(sel_pos);
  assign s_tready = (state == wrss_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wrss_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = wrss_pkg::ST_EXEC;
      end
      wrss_pkg::ST_EXEC: begin
        if (req_q == wrss_pkg::REQ_INIT)                 state_next = wrss_pkg::ST_DIV;
        else if (req_q == wrss_pkg::REQ_STEAL && !bad_q) state_next = wrss_pkg::ST_WAVE;
        else                                             state_next = wrss_pkg::ST_FINISH;
      end
      wrss_pkg::ST_DIV: begin
        if (div_last) state_next = wrss_pkg::ST_WAVE;
      end
      wrss_pkg::ST_WAVE: begin
        if (tok_vec[MAX_WORKERS-1]) state_next = wrss_pkg::ST_FINISH;
      end
      wrss_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = wrss_pkg::ST_IDLE;
      end
      default: state_next = wrss_pkg::ST_IDLE;
    endcase
  end

  // outputs to the datapath
  always_comb begin
    ctrl.op    = wrss_pkg::CELL_IDLE;
    ctrl.wid   = wid_q;
    ctrl.n     = n;
    ctrl.extra = extra;
    ctrl.take  = 1'b0;
    inject     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      wrss_pkg::ST_EXEC: begin
        unique case (req_q)
          wrss_pkg::REQ_INIT:     div_start = 1'b1;
          wrss_pkg::REQ_NEXT:     if (!bad_q) ctrl.op = wrss_pkg::CELL_NEXT;
          wrss_pkg::REQ_STEAL:    inject = !bad_q;
          wrss_pkg::REQ_RST_ENDS: ctrl.op = wrss_pkg::CELL_RST_ENDS;
          wrss_pkg::REQ_RST_POS:  ctrl.op = wrss_pkg::CELL_RST_POS;
          default: ;
        endcase
      end
      wrss_pkg::ST_DIV: begin
        inject = div_last;
      end
      wrss_pkg::ST_WAVE: begin
        if (req_q == wrss_pkg::REQ_INIT) begin
          ctrl.op = wrss_pkg::CELL_INIT;
        end else begin
          ctrl.op   = wrss_pkg::CELL_STEAL;
          ctrl.take = any_hit && !granted_q;  // first donor only
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wrss_pkg::ST_IDLE;
      granted_q <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        granted_q <= 1'b0;
      end else if (state == wrss_pkg::ST_EXEC && req_q == wrss_pkg::REQ_NEXT && !bad_q) begin
        granted_q <= (next_pos < sel_wend);
      end else if (ctrl.take) begin
        granted_q <= 1'b1;
      end
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= s_tdata[2:0];
      wid_q <= s_tdata[6:3];
      bad_q <= ({1'b0, s_tdata[6:3]} >= n);
    end
    if (load_out) begin
      m_tdata <= {6'b0, bad_q, pos_out, granted_q};
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while busy");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == wrss_pkg::ST_FINISH))
    else $error("result raised outside finish");

  a_no_grant_when_bad: assert property (@(posedge clk) disable iff (rst)
    (state == wrss_pkg::ST_FINISH) && bad_q |-> !granted_q)
    else $error("grant on a bad worker id");

endmodule

### verif/tb_work_range_stealing_scheduler_core.sv
// Testbench for the work range stealing scheduler core: self-checking stream test with APB setup.
`timescale 1ns / 1ps

module tb_work_range_stealing_scheduler_core;

  localparam int          WORKER_SLOTS      = 16;
  localparam int          CYCLE_LIMIT       = 1000000;
  localparam int          HOLD_CYCLES       = 400;
  localparam logic [2:0]  ADDR_ITEM_COUNT   = 3'd0;
  localparam logic [2:0]  ADDR_WORKER_COUNT = 3'd4;
  localparam logic [2:0]  REQ_SPARE_6       = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7       = 3'd7;

  typedef struct packed {
    logic        granted;
    logic [31:0] position;
    logic        bad_worker;
  } grant_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // req_type[2:0], worker_id[6:3], zero pad[7]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // granted[0], position[32:1], bad_worker[33], zero pad[39:34]

  // predictor state
  logic [31:0] cfg_items = '0;
  logic [4:0]  cfg_workers = 5'd1;
  logic [31:0] base_limit [0:WORKER_SLOTS] = '{default: '0};
  logic [31:0] work_limit [0:WORKER_SLOTS] = '{default: '0};
  logic [31:0] cursor     [0:WORKER_SLOTS-1] = '{default: '0};

  grant_result_t pending_grants[$];
  grant_result_t want;
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  work_range_stealing_scheduler_core uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("work_range_stealing_scheduler_core test failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off whenever hold_tog flips
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        $error("result with no request pending: %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (m_tdata[0] !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[32:1] !== want.position) begin
          $error("position: expected %h, got %h", want.position, m_tdata[32:1]);
          mismatches++;
        end
        if (m_tdata[33] !== want.bad_worker) begin
          $error("bad_worker: expected %0d, got %0d", want.bad_worker, m_tdata[33]);
          mismatches++;
        end
      end
    end
  end

  function automatic int active_workers();
    if (cfg_workers == 0) return 1;
    if (cfg_workers > WORKER_SLOTS) return WORKER_SLOTS;
    return int'(cfg_workers);
  endfunction

  // updates the scheduler state for one request and returns its result
  function automatic grant_result_t apply_request(input logic [2:0] code, input logic [3:0] wid);
    grant_result_t r;
    int          n;
    logic [31:0] share;
    logic [31:0] extra;
    logic [31:0] top;
    logic        hit;
    n = active_workers();
    r.bad_worker = (int'(wid) >= n);
    r.granted = 1'b0;
    hit = 1'b0;
    case (code)
      wrss_pkg::REQ_INIT: begin
        share = cfg_items / n;
        extra = cfg_items % n;
        base_limit[0] = '0;
        for (int i = 0; i < WORKER_SLOTS; i++)
          base_limit[i+1] = (i < n) ? base_limit[i] + share + ((i < extra) ? 32'd1 : 32'd0)
                                    : 32'd0;
        work_limit = base_limit;
        for (int i = 0; i < WORKER_SLOTS; i++)
          cursor[i] = (i < n) ? base_limit[i] : 32'd0;
      end
      wrss_pkg::REQ_NEXT: begin
        if (!r.bad_worker) begin
          cursor[wid] = cursor[wid] + 32'd1;
          r.granted = (cursor[wid] < work_limit[wid+1]);
        end
      end
      wrss_pkg::REQ_STEAL: begin
        if (!r.bad_worker) begin
          // first higher worker with two or more items left loses its last one
          for (int i = int'(wid) + 1; i < n; i++) begin
            top = work_limit[i+1];
            if (!hit && cursor[i] < top && top - cursor[i] >= 32'd2) begin
              cursor[wid] = top - 32'd1;
              work_limit[i+1] = top - 32'd1;
              hit = 1'b1;
            end
          end
          r.granted = hit;
        end
      end
      wrss_pkg::REQ_RST_ENDS: work_limit = base_limit;
      wrss_pkg::REQ_RST_POS: begin
        for (int i = 0; i < n; i++)
          cursor[i] = base_limit[i];
      end
      default: ;
    endcase
    r.position = r.bad_worker ? 32'd0 : cursor[wid];
    return r;
  endfunction

  task automatic send_req(input logic [2:0] code, input logic [3:0] wid);
    grant_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, wid, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = apply_request(code, wid);
    pending_grants = {pending_grants, res};
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_ITEM_COUNT) cfg_items = value;
    else cfg_workers = value[4:0];
    readback = (addr == ADDR_ITEM_COUNT) ? cfg_items : {27'd0, cfg_workers};
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== readback) begin
      $error("prdata at %0d: expected %h, got %h", addr, readback, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] items, input logic [31:0] workers);
    drain_results();
    write_reg(ADDR_ITEM_COUNT, items);
    write_reg(ADDR_WORKER_COUNT, workers);
  endtask

  // nothing split yet: every limit is zero
  task automatic test_before_init();
    send_req(wrss_pkg::REQ_NEXT, 4'd0);
    send_req(wrss_pkg::REQ_STEAL, 4'd0);
    send_req(wrss_pkg::REQ_READ, 4'd1);
    send_req(REQ_SPARE_7, 4'd0);
  endtask

  task automatic test_small_split();
    configure(32'd10, 32'd3);
    send_req(wrss_pkg::REQ_INIT, 4'd0);
    send_req(wrss_pkg::REQ_NEXT, 4'd0);
    send_req(wrss_pkg::REQ_NEXT, 4'd2);
    send_req(wrss_pkg::REQ_STEAL, 4'd0);
    send_req(wrss_pkg::REQ_STEAL, 4'd2);     // no higher worker
    send_req(wrss_pkg::REQ_RST_ENDS, 4'd5);  // global even with a bad id
    send_req(wrss_pkg::REQ_RST_POS, 4'd3);
    send_req(REQ_SPARE_6, 4'd1);
    send_req(wrss_pkg::REQ_NEXT, 4'd15);
  endtask

  // full-range count; worker 14 steals near the top and then wraps its position
  task automatic test_wide_split();
    configure(32'hFFFF_FFFF, 32'd16);
    send_req(wrss_pkg::REQ_INIT, 4'd15);
    send_req(wrss_pkg::REQ_STEAL, 4'd14);
    send_req(wrss_pkg::REQ_NEXT, 4'd14);
    send_req(wrss_pkg::REQ_NEXT, 4'd14);
    send_req(wrss_pkg::REQ_STEAL, 4'd15);
    send_req(wrss_pkg::REQ_READ, 4'd15);
  endtask

  // zero and oversized worker counts; register change without a fresh init
  task automatic test_count_limits();
    configure(32'd5, 32'd0);
    send_req(wrss_pkg::REQ_INIT, 4'd0);
    send_req(wrss_pkg::REQ_NEXT, 4'd0);
    send_req(wrss_pkg::REQ_READ, 4'd1);
    configure(32'd7, 32'd31);
    send_req(wrss_pkg::REQ_READ, 4'd15);
    send_req(wrss_pkg::REQ_NEXT, 4'd3);
    send_req(wrss_pkg::REQ_INIT, 4'd0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int total);
    int          left;
    int          chunk;
    int          n;
    int          pick;
    logic [31:0] items;
    logic [31:0] workers;
    logic [2:0]  code;
    logic [3:0]  wid;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    left = total;
    while (left > 0) begin
      pick = $urandom_range(9);
      items = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
              (pick == 2) ? $urandom : $urandom_range(0, 80);
      pick = $urandom_range(9);
      workers = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(17, 31)
                                                  : $urandom_range(1, WORKER_SLOTS);
      configure(items, workers);
      n = active_workers();
      send_req(wrss_pkg::REQ_INIT, 4'($urandom_range(0, n - 1)));
      chunk = (left < 110) ? left : 110;
      left -= chunk;
      repeat (chunk - 1) begin
        pick = $urandom_range(99);
        if (pick < 45) code = wrss_pkg::REQ_NEXT;
        else if (pick < 75) code = wrss_pkg::REQ_STEAL;
        else if (pick < 80) code = wrss_pkg::REQ_READ;
        else if (pick < 85) code = wrss_pkg::REQ_RST_ENDS;
        else if (pick < 90) code = wrss_pkg::REQ_RST_POS;
        else if (pick < 93) code = wrss_pkg::REQ_INIT;
        else if (pick < 96) code = REQ_SPARE_6;
        else code = REQ_SPARE_7;
        wid = ($urandom_range(9) != 0) ? 4'($urandom_range(0, n - 1))
                                       : 4'($urandom_range(0, 15));
        send_req(code, wid);
      end
    end
  endtask

  // result side stalls long enough that the input backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    configure(32'd40, 32'd4);
    send_req(wrss_pkg::REQ_INIT, 4'd0);
    hold_tog <= ~hold_tog;
    repeat (40)
      send_req(($urandom_range(1) != 0) ? wrss_pkg::REQ_NEXT : wrss_pkg::REQ_STEAL,
               4'($urandom_range(0, 3)));
  endtask

  initial begin
    recv_idle_pct <= 30;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_before_init();
    test_small_split();
    test_wide_split();
    test_count_limits();
    test_random_traffic(26, 82, 550);
    test_random_traffic(82, 26, 550);
    test_random_traffic(0, 0, 550);
    test_output_backpressure();
    drain_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("work_range_stealing_scheduler_core test passed");
    else
      $display("work_range_stealing_scheduler_core test failed");
    $finish;
  end

endmodule
